[sv/afm_pkg.sv]
// shared types and codes for the allocate/free trace monitor
`default_nettype none
package afm_pkg;

  // command codes on in_command (the top code also ends the trace)
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // violation codes on out_violation
  localparam logic [2:0] V_NONE         = 3'd0;
  localparam logic [2:0] V_FREE_UNALLOC = 3'd1;
  localparam logic [2:0] V_DOUBLE_ALLOC = 3'd2;
  localparam logic [2:0] V_DOUBLE_FREE  = 3'd3;
  localparam logic [2:0] V_TABLE_FULL   = 3'd4;

  localparam int LEAK_W = 7;
  localparam logic [LEAK_W-1:0] LEAK_MAX = '1;

  // per-address typestate
  typedef enum logic [1:0] {
    ST_INIT    = 2'd0,
    ST_ALLOC   = 2'd1,
    ST_FREED   = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  // control part of a request as it moves down the chain
  typedef struct packed {
    logic              valid;
    logic              is_end;
    logic              is_free;
    logic              done;     // matched or inserted somewhere upstream
    status_t           st;       // typestate before this request
    logic [LEAK_W-1:0] leak;     // allocated entries seen so far (end only)
  } pkt_t;

endpackage
`default_nettype wire

[sv/afm_cell.sv]
// one table entry of the monitor chain: address, typestate and in-use flag
`default_nettype none
module afm_cell #(
  parameter int ADDR_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire afm_pkg::pkt_t         pkt_in,
  input  wire logic [ADDR_WIDTH-1:0] addr_in,
  output afm_pkg::pkt_t              pkt_out,
  output logic      [ADDR_WIDTH-1:0] addr_out
);
  import afm_pkg::*;

  logic                  used_r, used_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  status_t               st_r, st_nxt;
  pkt_t                  pkt_r, pkt_nxt;
  logic [ADDR_WIDTH-1:0] paddr_r;
  logic                  hit;
  status_t               cur;

  assign hit = used_r && (addr_r == addr_in);
  assign cur = hit ? st_r : ST_INIT;

  always_comb begin
    used_nxt = used_r;
    addr_nxt = addr_r;
    st_nxt   = st_r;
    pkt_nxt  = pkt_in;
    if (pkt_in.valid) begin
      if (pkt_in.is_end) begin
        if (used_r && st_r == ST_ALLOC && pkt_in.leak != LEAK_MAX) begin
          pkt_nxt.leak = pkt_in.leak + LEAK_W'(1);
        end
        used_nxt = 1'b0;
      end else if (!pkt_in.done && (hit || !used_r)) begin
        // matched entry, or first free entry: insert here
        used_nxt     = 1'b1;
        addr_nxt     = addr_in;
        pkt_nxt.done = 1'b1;
        pkt_nxt.st   = cur;
        if (!pkt_in.is_free) begin
          st_nxt = ST_ALLOC;
        end else begin
          st_nxt = (cur == ST_ALLOC) ? ST_FREED : ST_BADFREE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      pkt_r.valid <= 1'b0;
    end else if (adv) begin
      used_r      <= used_nxt;
      pkt_r.valid <= pkt_nxt.valid;
    end
    if (adv) begin
      addr_r        <= addr_nxt;
      st_r          <= st_nxt;
      paddr_r       <= addr_in;
      pkt_r.is_end  <= pkt_nxt.is_end;
      pkt_r.is_free <= pkt_nxt.is_free;
      pkt_r.done    <= pkt_nxt.done;
      pkt_r.st      <= pkt_nxt.st;
      pkt_r.leak    <= pkt_nxt.leak;
    end
  end

  assign pkt_out  = pkt_r;
  assign addr_out = paddr_r;

endmodule
`default_nettype wire

[sv/afm_tail.sv]
// end of the chain: violation decode, saturating counters and result register
`default_nettype none
module afm_tail #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire afm_pkg::pkt_t pkt_in,
  output logic               out_valid,
  output logic [2:0]         out_violation,
  output logic [31:0]        out_event_number,
  output logic               out_is_report,
  output logic [6:0]         out_leaked_total,
  output logic [31:0]        out_free_unallocated_total,
  output logic [31:0]        out_double_alloc_total,
  output logic [31:0]        out_double_free_total
);
  import afm_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic [COUNT_WIDTH-1:0] evt_r, evt_nxt;
  logic [COUNT_WIDTH-1:0] fu_r, fu_nxt, da_r, da_nxt, df_r, df_nxt;
  logic                   valid_r;
  logic [2:0]             viol_r, viol;
  logic [COUNT_WIDTH-1:0] num_r;
  logic                   rep_r;
  logic [LEAK_W-1:0]      leak_r;
  logic [COUNT_WIDTH-1:0] fut_r, dat_r, dft_r;

  always_comb begin
    viol = V_NONE;
    if (pkt_in.is_end) begin
      viol = V_NONE;
    end else if (!pkt_in.done) begin
      viol = V_TABLE_FULL;
    end else if (!pkt_in.is_free) begin
      if (pkt_in.st == ST_ALLOC) viol = V_DOUBLE_ALLOC;
    end else if (pkt_in.st == ST_INIT) begin
      viol = V_FREE_UNALLOC;
    end else if (pkt_in.st != ST_ALLOC) begin
      viol = V_DOUBLE_FREE;
    end
  end

  always_comb begin
    evt_nxt = evt_r;
    fu_nxt  = fu_r;
    da_nxt  = da_r;
    df_nxt  = df_r;
    if (pkt_in.valid) begin
      if (evt_r != CMAX) evt_nxt = evt_r + 1'b1;
      if (viol == V_FREE_UNALLOC && fu_r != CMAX) fu_nxt = fu_r + 1'b1;
      if (viol == V_DOUBLE_ALLOC && da_r != CMAX) da_nxt = da_r + 1'b1;
      if (viol == V_DOUBLE_FREE  && df_r != CMAX) df_nxt = df_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_r   <= '0;
      fu_r    <= '0;
      da_r    <= '0;
      df_r    <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      evt_r   <= evt_nxt;
      fu_r    <= fu_nxt;
      da_r    <= da_nxt;
      df_r    <= df_nxt;
      valid_r <= pkt_in.valid;
    end
    if (adv) begin
      viol_r <= viol;
      num_r  <= evt_nxt;
      rep_r  <= pkt_in.is_end;
      leak_r <= pkt_in.is_end ? pkt_in.leak : '0;
      fut_r  <= pkt_in.is_end ? fu_r : '0;
      dat_r  <= pkt_in.is_end ? da_r : '0;
      dft_r  <= pkt_in.is_end ? df_r : '0;
    end
  end

  assign out_valid                  = valid_r;
  assign out_violation              = viol_r;
  assign out_event_number           = 32'(num_r);
  assign out_is_report              = rep_r;
  assign out_leaked_total           = leak_r;
  assign out_free_unallocated_total = 32'(fut_r);
  assign out_double_alloc_total     = 32'(dat_r);
  assign out_double_free_total      = 32'(dft_r);

endmodule
`default_nettype wire

[sv/alloc_free_trace_monitor_core.sv]
// top level of the allocate/free trace monitor: cell chain and result stage
// Usage:
//   in_*  : one request per accepted edge (in_valid high, in_stall low);
//           in_command 0 allocate, 1 free, 2 or 3 end of trace; in_address
//           names the block, only its low ADDR_WIDTH bits are compared
//   out_* : exactly one result per request, in request order; accepted when
//           out_valid is high and out_stall is low
// Path: the first cell loads the request at the accepting edge, each later
//   cell registers it in turn and the result register last drives out_valid.
// Throughput: one request per cycle while out_stall does not hold the chain.
//   Each cell owns one table entry and sees requests in arrival order, so
//   requests follow each other down the chain with no gaps.
// Stall: while a result waits under out_stall the whole chain holds and
//   in_stall is raised; nothing is dropped or repeated.
// Reset: rst_n low for one edge empties the table and clears the event and
//   violation counters; no clearing pass is needed.
// End of trace: the request sweeps the chain, counts entries still
//   allocated (saturating at 127) and frees every cell it passes.
`default_nettype none
module alloc_free_trace_monitor_core #(
  parameter int ENTRIES     = 64,
  parameter int ADDR_WIDTH  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [63:0] in_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_violation,
  output logic [31:0]      out_event_number,
  output logic             out_is_report,
  output logic [6:0]       out_leaked_total,
  output logic [31:0]      out_free_unallocated_total,
  output logic [31:0]      out_double_alloc_total,
  output logic [31:0]      out_double_free_total
);
  import afm_pkg::*;

  // chain moves whenever the result register is free or being drained
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  pkt_t                  pkt  [ENTRIES+1];
  logic [ADDR_WIDTH-1:0] addr [ENTRIES+1];

  // request entering the first cell
  assign pkt[0] = '{
    valid:   in_valid,
    is_end:  (in_command == CMD_END) || (in_command[1] == 1'b1),
    is_free: (in_command == CMD_FREE),
    done:    1'b0,
    st:      ST_INIT,
    leak:    '0
  };
  assign addr[0] = in_address[ADDR_WIDTH-1:0];

  // row of table cells; used entries form a prefix of the chain except while an end-of-trace request sweeps it
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    afm_cell #(
      .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .pkt_in   (pkt[g]),
      .addr_in  (addr[g]),
      .pkt_out  (pkt[g+1]),
      .addr_out (addr[g+1])
    );
  end

  // violation decode, counters and result register
  afm_tail #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tail (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .adv                        (adv),
    .pkt_in                     (pkt[ENTRIES]),
    .out_valid                  (out_valid),
    .out_violation              (out_violation),
    .out_event_number           (out_event_number),
    .out_is_report              (out_is_report),
    .out_leaked_total           (out_leaked_total),
    .out_free_unallocated_total (out_free_unallocated_total),
    .out_double_alloc_total     (out_double_alloc_total),
    .out_double_free_total      (out_double_free_total)
  );

endmodule
`default_nettype wire

[sv/afm_checker.sv]
// port-level checks for the allocate/free trace monitor, bound to the top level
`default_nettype none
module afm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_violation,
  input wire logic [31:0] out_event_number,
  input wire logic        out_is_report,
  input wire logic [6:0]  out_leaked_total,
  input wire logic [31:0] out_free_unallocated_total,
  input wire logic [31:0] out_double_alloc_total,
  input wire logic [31:0] out_double_free_total
);
  import afm_pkg::*;

  // a report never carries a violation
  a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_report) |-> (out_violation == V_NONE))
    else $error("report result carries a violation");

  // totals only show on a report
  a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_report) |-> (out_leaked_total == 7'd0 &&
      out_free_unallocated_total == 32'd0 && out_double_alloc_total == 32'd0 &&
      out_double_free_total == 32'd0))
    else $error("totals on a non-report result");

  // event numbers are one-based and never go backwards
  a_event_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=>
      (!out_valid || (out_event_number >= $past(out_event_number) &&
                      out_event_number != 32'd0)))
    else $error("event number out of order");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_event_number) && $stable(out_violation)))
    else $error("stalled result changed");

endmodule

bind alloc_free_trace_monitor_core afm_checker u_afm_checker (.*);
`default_nettype wire
